/* rtl/bwlp_pkg.sv */
// shared types, constants and fixed-point helpers of the butterworth coefficient designer
`default_nettype none
package bwlp_pkg;

   localparam int DEF_MAX_ORDER      = 8;
   localparam int DEF_COEF_FRAC_BITS = 24;

   localparam int QF           = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int BINOM_W      = 16;

   localparam logic signed [63:0] QONE        = 64'sd1 << QF;
   localparam logic        [63:0] QCAP        = 64'd1 << 62;
   localparam logic        [31:0] HALF_PI_PH  = 32'd1 << 30;
   localparam logic        [31:0] PI_PH       = 32'd1 << 31;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // one entry of the expansion memory: complex coefficient and binomial term
   typedef struct packed {
      logic signed [63:0]       cr;
      logic signed [63:0]       ci;
      logic        [BINOM_W-1:0] bn;
   } entry_type;

   function automatic logic signed [32:0] atan_phase(input logic [4:0] idx);
      logic signed [32:0] r;
      unique case (idx)
         5'd0:  r = 33'sd536870912;
         5'd1:  r = 33'sd316933406;
         5'd2:  r = 33'sd167458907;
         5'd3:  r = 33'sd85004756;
         5'd4:  r = 33'sd42667331;
         5'd5:  r = 33'sd21354465;
         5'd6:  r = 33'sd10679838;
         5'd7:  r = 33'sd5340245;
         5'd8:  r = 33'sd2670163;
         5'd9:  r = 33'sd1335087;
         5'd10: r = 33'sd667544;
         5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;
         5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;
         5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;
         5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;
         5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;
         5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;
         5'd23: r = 33'sd81;
         5'd24: r = 33'sd41;
         5'd25: r = 33'sd20;
         5'd26: r = 33'sd10;
         5'd27: r = 33'sd5;
         5'd28: r = 33'sd3;
         5'd29: r = 33'sd1;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
      logic [63:0] c;
      c = (m > QCAP) ? QCAP : m;
      return neg ? -$signed(c) : $signed(c);
   endfunction

   // round to nearest of a q.30 product magnitude, saturating at the cap
   function automatic logic signed [63:0] qmul_fix(input logic [127:0] prod, input logic neg);
      logic [127:0] rnd;
      logic [63:0]  r;
      rnd = prod + (128'd1 << (QF - 1));
      if (rnd[127:94] != '0) r = QCAP;
      else r = rnd[93:30];
      return signed_of(r, neg);
   endfunction

   function automatic logic [63:0] qdiv_divisor(input logic signed [63:0] den);
      return (den <= 0) ? 64'(QONE) : 64'(den);
   endfunction

   function automatic logic [63:0] qdiv_dividend(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
      logic [63:0] un;
      logic [63:0] ud;
      un = mag(num);
      ud = qdiv_divisor(den);
      if (un >= (64'd1 << 33)) un = (64'd1 << 33) - 64'd1;
      return (un << QF) + (ud >> 1);
   endfunction

endpackage
`default_nettype wire

/* rtl/bwlp_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module bwlp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                    clock,
   input  wire                    wr_en,
   input  wire  [ADDR_W-1:0]      wr_addr,
   input  wire  [WIDTH-1:0]       wr_data,
   input  wire                    rd_en,
   input  wire  [ADDR_W-1:0]      rd_addr,
   output logic [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* rtl/butterworth_lowpass_coef_design.sv */
// butterworth lowpass coefficient designer top level
`default_nettype none
// Takes an order n and a cutoff (fraction of Nyquist, Q0.16) and returns n+1 items holding
// b_k and a_k in signed Q(32-COEF_FRAC_BITS).COEF_FRAC_BITS, k = 0..n, last_coef on k = n.
// An order of 0 or above MAX_ORDER gives one item with bad_request set and zero coefficients.
// One request is worked at a time; req_ready is high only between requests. A valid request
// runs three 64-step restoring divides and one 30-step CORDIC per pole, plus four sequential
// 5-step multiplies per read-modify-write step of the complex expansion, whose coefficients
// live in a small ram. No clearing pass is needed.
module butterworth_lowpass_coef_design #(
   parameter int MAX_ORDER      = bwlp_pkg::DEF_MAX_ORDER,
   parameter int COEF_FRAC_BITS = bwlp_pkg::DEF_COEF_FRAC_BITS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [3:0]         req_filter_order,
   input  wire  [15:0]        req_cutoff_fraction,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [3:0]         rsp_coef_index,
   output logic signed [31:0] rsp_numer_coef,
   output logic signed [31:0] rsp_denom_coef,
   output logic               rsp_last_coef,
   output logic               rsp_bad_request
);
   localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ENT_W  = $bits(bwlp_pkg::entry_type);
   localparam int SHR    = (COEF_FRAC_BITS < bwlp_pkg::QF) ? bwlp_pkg::QF - COEF_FRAC_BITS : 1;
   localparam int SHL    = (COEF_FRAC_BITS >= bwlp_pkg::QF) ? COEF_FRAC_BITS - bwlp_pkg::QF : 0;

   typedef enum logic [4:0] {
      S_IDLE, S_ERR, S_WAIT, S_ST, S_SH, S_PPH, S_PCOR, S_PSC, S_D, S_PR, S_PIMM, S_PIM,
      S_DEN, S_EXP0, S_RDREQ, S_RD, S_M1, S_M2, S_M3, S_M4, S_WR, S_ZERO, S_ODD, S_ODDW,
      S_NUM, S_NUMW, S_SF, S_SFW, S_OUT, S_ORD, S_OEMIT
   } state_type;

   // q.30 to output format with rounding and saturation
   function automatic logic [31:0] to_coef(input logic signed [63:0] v);
      logic        neg;
      logic [64:0] um;
      logic [64:0] m;
      logic [31:0] r;
      neg = v[63];
      um  = {1'b0, bwlp_pkg::mag(v)};
      if (COEF_FRAC_BITS < bwlp_pkg::QF) m = (um + (65'd1 << (SHR - 1))) >> SHR;
      else if (um >= (65'd1 << 33)) m = 65'd1 << 40;
      else m = um << SHL;
      if (neg) begin
         if (m > 65'h0_8000_0000) m = 65'h0_8000_0000;
         r = 32'(65'h1_0000_0000 - m);
      end else begin
         if (m > 65'h0_7FFF_FFFF) m = 65'h0_7FFF_FFFF;
         r = m[31:0];
      end
      return r;
   endfunction

   state_type state_ff, ret_ff;

   // launch registers for the shared units
   logic               mul_go_ff, div_go_ff, cor_go_ff;
   logic signed [63:0] mul_x_ff, mul_y_ff;
   logic [63:0]        div_n_ff, div_d_ff;
   logic               div_neg_ff;
   logic [31:0]        cor_ph_ff;

   // request and working values
   logic [3:0]         n_ff, i_ff, j_ff, k_ff;
   logic [15:0]        cut_ff;
   logic signed [63:0] st_ff, ct_ff, sh_ff, ch_ff, cp_ff, d_ff, pr_ff, pim_ff;
   logic signed [63:0] den_ff, num_ff, sf_ff, acc_cr_ff, acc_ci_ff;
   bwlp_pkg::entry_type carry_ff, ent_ff;

   logic               rsp_valid_ff, rsp_last_ff, rsp_bad_ff;
   logic [3:0]         rsp_index_ff;
   logic [31:0]        rsp_numer_ff, rsp_denom_ff;

   // ---------------- multiplier: 64x64 magnitude from four 32x32 partials
   logic               mul_busy_ff, mul_neg_ff;
   logic [2:0]         mul_cnt_ff;
   logic [63:0]        mul_a_ff, mul_b_ff, mul_pp_ff;
   logic [127:0]       mul_acc_ff;
   logic [31:0]        mul_asel, mul_bsel;
   logic [63:0]        mul_pp_in;
   logic [127:0]       mul_add;

   always_comb begin
      mul_asel = (mul_cnt_ff[1]) ? mul_a_ff[63:32] : mul_a_ff[31:0];
      mul_bsel = (mul_cnt_ff[0]) ? mul_b_ff[63:32] : mul_b_ff[31:0];
      mul_pp_in = mul_asel * mul_bsel;
      unique case (mul_cnt_ff)
         3'd1:    mul_add = {64'b0, mul_pp_ff};
         3'd2:    mul_add = {32'b0, mul_pp_ff, 32'b0};
         3'd3:    mul_add = {32'b0, mul_pp_ff, 32'b0};
         3'd4:    mul_add = {mul_pp_ff, 64'b0};
         default: mul_add = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_cnt_ff  <= '0;
      end else if (mul_go_ff) begin
         mul_busy_ff <= 1'b1;
         mul_cnt_ff  <= '0;
         mul_a_ff    <= bwlp_pkg::mag(mul_x_ff);
         mul_b_ff    <= bwlp_pkg::mag(mul_y_ff);
         mul_neg_ff  <= mul_x_ff[63] ^ mul_y_ff[63];
         mul_acc_ff  <= '0;
      end else if (mul_busy_ff) begin
         mul_pp_ff  <= mul_pp_in;
         mul_acc_ff <= mul_acc_ff + mul_add;
         mul_cnt_ff <= mul_cnt_ff + 3'd1;
         if (mul_cnt_ff == 3'd4) begin
            mul_busy_ff <= 1'b0;
         end
      end
   end

   logic signed [63:0] qmul_res, prod_lo;
   assign qmul_res = bwlp_pkg::qmul_fix(mul_acc_ff, mul_neg_ff);
   assign prod_lo  = mul_neg_ff ? -$signed(mul_acc_ff[63:0]) : $signed(mul_acc_ff[63:0]);

   // ---------------- restoring divider, one quotient bit per cycle
   logic               div_busy_ff;
   logic [5:0]         div_cnt_ff;
   logic [63:0]        div_q_ff, div_dsr_ff;
   logic [64:0]        div_r_ff;
   logic [64:0]        div_trial;
   logic               div_ge;

   assign div_trial = {div_r_ff[63:0], div_q_ff[63]};
   assign div_ge    = div_trial >= {1'b0, div_dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_go_ff) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
         div_q_ff    <= div_n_ff;
         div_dsr_ff  <= div_d_ff;
         div_r_ff    <= '0;
      end else if (div_busy_ff) begin
         div_r_ff   <= div_ge ? div_trial - {1'b0, div_dsr_ff} : div_trial;
         div_q_ff   <= {div_q_ff[62:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (div_cnt_ff == 6'd63) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   logic signed [63:0] qdiv_res;
   assign qdiv_res = bwlp_pkg::signed_of(div_q_ff, div_neg_ff);

   // ---------------- rotation-mode cordic over [0, pi/2], mirrored above
   logic               cor_busy_ff, cor_flip_ff;
   logic [4:0]         cor_cnt_ff;
   logic signed [33:0] cor_x_ff, cor_y_ff;
   logic signed [32:0] cor_z_ff;
   logic [31:0]        cor_ph_c;
   logic signed [32:0] cor_z_c;
   logic               cor_flip_c;
   logic signed [33:0] cor_xs, cor_ys;
   logic signed [32:0] cor_at;

   always_comb begin
      cor_ph_c   = (cor_ph_ff > bwlp_pkg::PI_PH) ? bwlp_pkg::PI_PH : cor_ph_ff;
      cor_flip_c = cor_ph_c > bwlp_pkg::HALF_PI_PH;
      cor_z_c    = cor_flip_c ? $signed({1'b0, bwlp_pkg::PI_PH - cor_ph_c})
                              : $signed({1'b0, cor_ph_c});
      cor_xs     = cor_x_ff >>> cor_cnt_ff;
      cor_ys     = cor_y_ff >>> cor_cnt_ff;
      cor_at     = bwlp_pkg::atan_phase(cor_cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_busy_ff <= 1'b0;
         cor_cnt_ff  <= '0;
      end else if (cor_go_ff) begin
         cor_busy_ff <= 1'b1;
         cor_cnt_ff  <= '0;
         cor_x_ff    <= bwlp_pkg::CORDIC_GAIN;
         cor_y_ff    <= '0;
         cor_z_ff    <= cor_z_c;
         cor_flip_ff <= cor_flip_c;
      end else if (cor_busy_ff) begin
         if (cor_z_ff >= 0) begin
            cor_x_ff <= cor_x_ff - cor_ys;
            cor_y_ff <= cor_y_ff + cor_xs;
            cor_z_ff <= cor_z_ff - cor_at;
         end else begin
            cor_x_ff <= cor_x_ff + cor_ys;
            cor_y_ff <= cor_y_ff - cor_xs;
            cor_z_ff <= cor_z_ff + cor_at;
         end
         cor_cnt_ff <= cor_cnt_ff + 5'd1;
         if (cor_cnt_ff == 5'(bwlp_pkg::CORDIC_STEPS - 1)) begin
            cor_busy_ff <= 1'b0;
         end
      end
   end

   logic signed [63:0] cor_sin, cor_cos;
   assign cor_sin = 64'(cor_y_ff);
   assign cor_cos = cor_flip_ff ? -64'(cor_x_ff) : 64'(cor_x_ff);

   // ---------------- expansion memory
   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   bwlp_pkg::entry_type ram_wdata, ram_rdata;
   logic [ENT_W-1:0]    ram_rd_raw;

   always_comb begin
      ram_re    = (state_ff == S_RDREQ) || ((state_ff == S_OUT) && (k_ff != 4'd0));
      ram_raddr = (state_ff == S_RDREQ) ? ADDR_W'(j_ff - 4'd1) : ADDR_W'(k_ff - 4'd1);
      ram_we    = (state_ff == S_WR) || (state_ff == S_ZERO);
      ram_waddr = (state_ff == S_WR) ? ADDR_W'(j_ff) : '0;
      if (state_ff == S_WR) begin
         ram_wdata.cr = carry_ff.cr + acc_cr_ff;
         ram_wdata.ci = carry_ff.ci + acc_ci_ff;
         ram_wdata.bn = carry_ff.bn + ent_ff.bn;
      end else begin
         ram_wdata.cr = carry_ff.cr + pr_ff;
         ram_wdata.ci = carry_ff.ci + pim_ff;
         ram_wdata.bn = carry_ff.bn + bwlp_pkg::BINOM_W'(1);
      end
   end

   bwlp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ORDER), .ADDR_W(ADDR_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_raw)
   );
   assign ram_rdata = bwlp_pkg::entry_type'(ram_rd_raw);

   // ---------------- sequencer
   logic               out_free, units_idle, req_bad;
   logic signed [63:0] d_c;
   logic               mul_go_in, div_go_in, cor_go_in, rsp_load;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign units_idle = !mul_busy_ff && !div_busy_ff && !cor_busy_ff &&
                       !mul_go_ff && !div_go_ff && !cor_go_ff;
   assign d_c        = bwlp_pkg::QONE + qmul_res;
   assign req_bad    = (req_filter_order == 4'd0) ||
                       (5'(req_filter_order) > 5'(MAX_ORDER));

   // unit launches and output loads, one per state
   always_comb begin
      mul_go_in = 1'b0;
      div_go_in = 1'b0;
      cor_go_in = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE:                  cor_go_in = req_valid && !req_bad;
         S_ST, S_PCOR:            cor_go_in = 1'b1;
         S_PPH, S_D, S_PIMM, S_SF: div_go_in = 1'b1;
         S_PSC, S_PR, S_RD, S_M1, S_M2, S_M3, S_ORD: mul_go_in = 1'b1;
         S_PIM:                   mul_go_in = i_ff < (n_ff >> 1);
         S_ODD:                   mul_go_in = n_ff[0];
         S_NUM:                   mul_go_in = i_ff != n_ff;
         S_OUT:                   mul_go_in = k_ff == 4'd0;
         S_ERR, S_OEMIT:          rsp_load  = out_free;
         default:                 mul_go_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         cor_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff <= mul_go_in;
         div_go_ff <= div_go_in;
         cor_go_ff <= cor_go_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff   <= req_filter_order;
                  cut_ff <= req_cutoff_fraction;
                  if (req_bad) begin
                     state_ff <= S_ERR;
                  end else begin
                     cor_ph_ff <= {1'b0, req_cutoff_fraction, 15'b0};
                     ret_ff    <= S_ST;
                     state_ff  <= S_WAIT;
                  end
               end
            end
            S_ERR: begin
               if (rsp_load) begin
                  rsp_index_ff <= '0;
                  rsp_numer_ff <= '0;
                  rsp_denom_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  rsp_bad_ff   <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_WAIT: begin
               if (units_idle) begin
                  state_ff <= ret_ff;
               end
            end
            S_ST: begin
               st_ff     <= cor_sin;
               ct_ff     <= cor_cos;
               cor_ph_ff <= {2'b0, cut_ff, 14'b0};
               ret_ff    <= S_SH;
               state_ff  <= S_WAIT;
            end
            S_SH: begin
               sh_ff    <= cor_sin;
               ch_ff    <= cor_cos;
               i_ff     <= '0;
               den_ff   <= bwlp_pkg::QONE;
               state_ff <= S_PPH;
            end
            S_PPH: begin
               // pole phase (2i+1) * pi / (2n)
               div_n_ff   <= {28'b0, i_ff, 1'b1, 31'b0};
               div_d_ff   <= {59'b0, n_ff, 1'b0};
               div_neg_ff <= 1'b0;
               ret_ff     <= S_PCOR;
               state_ff   <= S_WAIT;
            end
            S_PCOR: begin
               cor_ph_ff <= div_q_ff[31:0];
               ret_ff    <= S_PSC;
               state_ff  <= S_WAIT;
            end
            S_PSC: begin
               cp_ff     <= cor_cos;
               mul_x_ff  <= st_ff;
               mul_y_ff  <= cor_sin;
               ret_ff    <= S_D;
               state_ff  <= S_WAIT;
            end
            S_D: begin
               d_ff       <= d_c;
               div_n_ff   <= bwlp_pkg::qdiv_dividend(ct_ff, d_c);
               div_d_ff   <= bwlp_pkg::qdiv_divisor(d_c);
               div_neg_ff <= ct_ff[63];
               ret_ff     <= S_PR;
               state_ff   <= S_WAIT;
            end
            S_PR: begin
               pr_ff     <= -qdiv_res;
               mul_x_ff  <= st_ff;
               mul_y_ff  <= cp_ff;
               ret_ff    <= S_PIMM;
               state_ff  <= S_WAIT;
            end
            S_PIMM: begin
               div_n_ff   <= bwlp_pkg::qdiv_dividend(qmul_res, d_ff);
               div_d_ff   <= bwlp_pkg::qdiv_divisor(d_ff);
               div_neg_ff <= qmul_res[63];
               ret_ff     <= S_PIM;
               state_ff   <= S_WAIT;
            end
            S_PIM: begin
               pim_ff <= -qdiv_res;
               // gain denominator collects the first half of the pole terms
               if (i_ff < (n_ff >> 1)) begin
                  mul_x_ff  <= den_ff;
                  mul_y_ff  <= d_ff;
                  ret_ff    <= S_DEN;
                  state_ff  <= S_WAIT;
               end else begin
                  state_ff <= S_EXP0;
               end
            end
            S_DEN: begin
               den_ff   <= qmul_res;
               state_ff <= S_EXP0;
            end
            S_EXP0: begin
               // entry i is still empty, so the first carried value is zero
               j_ff     <= i_ff;
               carry_ff <= '0;
               state_ff <= (i_ff == 4'd0) ? S_ZERO : S_RDREQ;
            end
            S_RDREQ: begin
               state_ff <= S_RD;
            end
            S_RD: begin
               ent_ff    <= ram_rdata;
               mul_x_ff  <= pr_ff;
               mul_y_ff  <= ram_rdata.cr;
               ret_ff    <= S_M1;
               state_ff  <= S_WAIT;
            end
            S_M1: begin
               acc_cr_ff <= qmul_res;
               mul_x_ff  <= pim_ff;
               mul_y_ff  <= ent_ff.ci;
               ret_ff    <= S_M2;
               state_ff  <= S_WAIT;
            end
            S_M2: begin
               acc_cr_ff <= acc_cr_ff - qmul_res;
               mul_x_ff  <= pr_ff;
               mul_y_ff  <= ent_ff.ci;
               ret_ff    <= S_M3;
               state_ff  <= S_WAIT;
            end
            S_M3: begin
               acc_ci_ff <= qmul_res;
               mul_x_ff  <= pim_ff;
               mul_y_ff  <= ent_ff.cr;
               ret_ff    <= S_M4;
               state_ff  <= S_WAIT;
            end
            S_M4: begin
               acc_ci_ff <= acc_ci_ff + qmul_res;
               state_ff  <= S_WR;
            end
            S_WR: begin
               // the entry just read becomes the old value of the next lower index
               carry_ff <= ent_ff;
               j_ff     <= j_ff - 4'd1;
               state_ff <= (j_ff == 4'd1) ? S_ZERO : S_RDREQ;
            end
            S_ZERO: begin
               i_ff     <= i_ff + 4'd1;
               state_ff <= ((i_ff + 4'd1) == n_ff) ? S_ODD : S_PPH;
            end
            S_ODD: begin
               num_ff <= bwlp_pkg::QONE;
               i_ff   <= '0;
               if (n_ff[0]) begin
                  mul_x_ff  <= den_ff;
                  mul_y_ff  <= sh_ff + ch_ff;
                  ret_ff    <= S_ODDW;
                  state_ff  <= S_WAIT;
               end else begin
                  state_ff <= S_NUM;
               end
            end
            S_ODDW: begin
               den_ff   <= qmul_res;
               state_ff <= S_NUM;
            end
            S_NUM: begin
               if (i_ff == n_ff) begin
                  state_ff <= S_SF;
               end else begin
                  mul_x_ff  <= num_ff;
                  mul_y_ff  <= sh_ff;
                  ret_ff    <= S_NUMW;
                  state_ff  <= S_WAIT;
               end
            end
            S_NUMW: begin
               num_ff   <= qmul_res;
               i_ff     <= i_ff + 4'd1;
               state_ff <= S_NUM;
            end
            S_SF: begin
               div_n_ff   <= bwlp_pkg::qdiv_dividend(num_ff, den_ff);
               div_d_ff   <= bwlp_pkg::qdiv_divisor(den_ff);
               div_neg_ff <= num_ff[63];
               ret_ff     <= S_SFW;
               state_ff   <= S_WAIT;
            end
            S_SFW: begin
               sf_ff    <= qdiv_res;
               k_ff     <= '0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (k_ff == 4'd0) begin
                  mul_x_ff  <= sf_ff;
                  mul_y_ff  <= 64'sd1;
                  ret_ff    <= S_OEMIT;
                  state_ff  <= S_WAIT;
               end else begin
                  state_ff <= S_ORD;
               end
            end
            S_ORD: begin
               ent_ff    <= ram_rdata;
               mul_x_ff  <= sf_ff;
               mul_y_ff  <= $signed(64'(ram_rdata.bn));
               ret_ff    <= S_OEMIT;
               state_ff  <= S_WAIT;
            end
            S_OEMIT: begin
               if (rsp_load) begin
                  rsp_index_ff <= k_ff;
                  rsp_numer_ff <= to_coef(prod_lo);
                  rsp_denom_ff <= (k_ff == 4'd0) ? to_coef(bwlp_pkg::QONE) : to_coef(ent_ff.cr);
                  rsp_last_ff  <= k_ff == n_ff;
                  rsp_bad_ff   <= 1'b0;
                  k_ff         <= k_ff + 4'd1;
                  state_ff     <= (k_ff == n_ff) ? S_IDLE : S_OUT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coef_index  = rsp_index_ff;
   assign rsp_numer_coef  = $signed(rsp_numer_ff);
   assign rsp_denom_coef  = $signed(rsp_denom_ff);
   assign rsp_last_coef   = rsp_last_ff;
   assign rsp_bad_request = rsp_bad_ff;

   // ---------------- checks
   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mul_busy_ff && !div_busy_ff && !cor_busy_ff)
      else $error("arithmetic unit busy while taking a new item");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_busy_ff, div_busy_ff, cor_busy_ff}))
      else $error("more than one arithmetic unit running");

   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_waddr != ram_raddr)
      else $error("ram read and write of the same entry in one cycle");

   a_bad_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_last_coef && rsp_coef_index == 4'd0)
      else $error("error item not a single last item");
endmodule
`default_nettype wire
